// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the queue core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, held off while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen on a rising edge of clk outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/cmbq_pkg.sv =====
// types and constants of the class-matched bounded queue
package cmbq_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int VAL_W  = 16;
    localparam int CLS_W  = 2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);

    // opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // value classes
    localparam logic [CLS_W-1:0] CLS_EVEN  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_ODD   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_PRIME = 2'd2;
    localparam logic [CLS_W-1:0] CLS_NONE  = 2'd3;

    typedef struct packed {
        logic                    opcode;
        logic signed [VAL_W-1:0] item_value;
        logic [CLS_W-1:0]        consumer_class;
    } in_t;

    typedef struct packed {
        logic                    op_ok;
        logic signed [VAL_W-1:0] taken_value;
        logic [CNT_W-1:0]        occupancy;
    } out_t;

    // one queue entry as held in memory
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

// ===== rtl/core/class_matched_bounded_queue_core.sv =====
// Class-matched bounded queue: a FIFO of signed 16-bit values held in a 16-entry ram, each
// entry stored with its class (even, odd or prime). A push is classified on entry by trial
// division and written at the tail; a take scans from the head for the oldest entry of the
// asked class, returns it and closes the gap by copying later entries down one place. One item
// is worked at a time; the output register lets the next item in while a result waits, and the
// block is ready for the next item in the cycle that the result appears. A rejected push, or a
// take that cannot match (class three or an empty queue), goes straight to the result; a push of
// an even value, of a value below two or of two itself is written at once; an odd push above two
// is tried against odd divisors 3, 5, ... up to the square root, each by the bit-serial
// remainder unit at one bit a cycle, and stops at the first divisor that leaves no remainder;
// a take reads entries one by one through the single registered ram read port until one of the
// asked class hits, then copies each later entry down one place with a read and a write; a take
// that misses scans every entry.
`include "assert_macros.svh"

module class_matched_bounded_queue_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cmbq_pkg::in_t             in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cmbq_pkg::out_t            out_data,
    input  logic                      cfg_we,
    input  logic [cmbq_pkg::CNT_W-1:0] cfg_wdata
);

    import cmbq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_PUSH_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [VAL_W-1:0]        val_reg;
    logic [CLS_W-1:0]        cls_reg;
    logic [7:0]              div_reg;
    logic [15:0]             sq_reg;
    logic [7:0]              rem_reg;
    logic [3:0]              bit_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        limit_reg;
    logic                    res_ok_reg;
    logic [VAL_W-1:0]        res_taken_reg;
    logic                    out_valid_reg;
    out_t                    out_reg;

    logic [CNT_W-1:0]        limit_eff;
    logic [CNT_W-1:0]        idx_inc;
    logic [8:0]              rem_shift;
    logic [7:0]              rem_next;
    logic [15:0]             sq_next;
    logic                    accept;

    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    entry_t                  ram_wr_data;
    logic                    ram_rd_en;
    logic [ADDR_W-1:0]       ram_rd_addr;
    entry_t                  ram_rd_data;

    // handshake and derived values
    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign limit_eff = (limit_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : limit_reg;
    assign idx_inc   = idx_reg + CNT_W'(1);

    // one restoring step of the remainder, msb first
    always_comb
    begin
        rem_shift = {rem_reg, val_reg[bit_reg]};
        if (rem_shift >= {1'b0, div_reg})
        begin
            rem_next = 8'(rem_shift - {1'b0, div_reg});
        end
        else
        begin
            rem_next = rem_shift[7:0];
        end
        // (d+2)^2 = d^2 + 4d + 4
        sq_next = sq_reg + 16'({div_reg, 2'b00}) + 16'd4;
    end

    // ram port control
    always_comb
    begin
        ram_wr_en   = (state_reg == ST_PUSH_WR) || (state_reg == ST_SHIFT_WR);
        ram_rd_en   = (state_reg == ST_SCAN_RD) || (state_reg == ST_SHIFT_RD);
        ram_rd_addr = (state_reg == ST_SHIFT_RD) ? idx_inc[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
        if (state_reg == ST_PUSH_WR)
        begin
            ram_wr_addr       = count_reg[ADDR_W-1:0];
            ram_wr_data.cls   = cls_reg;
            ram_wr_data.value = val_reg;
        end
        else
        begin
            ram_wr_addr = idx_reg[ADDR_W-1:0];
            ram_wr_data = ram_rd_data;
        end
    end

    cmbq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // control state machine, queue count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            // result taken with no new one ready to replace it
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        val_reg       <= in_data.item_value;
                        res_ok_reg    <= 1'b0;
                        res_taken_reg <= '0;
                        idx_reg       <= '0;
                        if (in_data.opcode == OP_PUSH)
                        begin
                            if (count_reg >= limit_eff)
                            begin
                                // queue full
                                state_reg <= ST_DONE;
                            end
                            else if (in_data.item_value < 16'sd2)
                            begin
                                cls_reg   <= in_data.item_value[0] ? CLS_ODD : CLS_EVEN;
                                state_reg <= ST_PUSH_WR;
                            end
                            else if (in_data.item_value == 16'sd2)
                            begin
                                cls_reg   <= CLS_PRIME;
                                state_reg <= ST_PUSH_WR;
                            end
                            else if (!in_data.item_value[0])
                            begin
                                cls_reg   <= CLS_EVEN;
                                state_reg <= ST_PUSH_WR;
                            end
                            else
                            begin
                                div_reg   <= 8'd3;
                                sq_reg    <= 16'd9;
                                state_reg <= ST_CHECK;
                            end
                        end
                        else if (in_data.consumer_class == CLS_NONE || count_reg == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            cls_reg   <= in_data.consumer_class;
                            state_reg <= ST_SCAN_RD;
                        end
                    end
                end

                // stop once the divisor passes the square root
                ST_CHECK:
                begin
                    if (sq_reg > {1'b0, val_reg[14:0]})
                    begin
                        cls_reg   <= CLS_PRIME;
                        state_reg <= ST_PUSH_WR;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        bit_reg   <= 4'd14;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (bit_reg == 4'd0)
                    begin
                        if (rem_next == 8'd0)
                        begin
                            cls_reg   <= CLS_ODD;
                            state_reg <= ST_PUSH_WR;
                        end
                        else
                        begin
                            div_reg   <= div_reg + 8'd2;
                            sq_reg    <= sq_next;
                            state_reg <= ST_CHECK;
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        bit_reg <= bit_reg - 4'd1;
                    end
                end

                ST_PUSH_WR:
                begin
                    count_reg  <= count_reg + CNT_W'(1);
                    res_ok_reg <= 1'b1;
                    state_reg  <= ST_DONE;
                end

                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CHK;
                end

                ST_SCAN_CHK:
                begin
                    if (ram_rd_data.cls == cls_reg)
                    begin
                        res_taken_reg <= ram_rd_data.value;
                        state_reg     <= ST_SHIFT_RD;
                    end
                    else if (idx_inc == count_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= ST_SCAN_RD;
                    end
                end

                // move later entries down one place
                ST_SHIFT_RD:
                begin
                    if (idx_inc == count_reg)
                    begin
                        count_reg  <= count_reg - CNT_W'(1);
                        res_ok_reg <= 1'b1;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SHIFT_WR;
                    end
                end

                ST_SHIFT_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= ST_SHIFT_RD;
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg.op_ok       <= res_ok_reg;
                        out_reg.taken_value <= res_taken_reg;
                        out_reg.occupancy   <= count_reg;
                        state_reg           <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // checks
    `ASSERT_NEVER(a_count_over_depth, count_reg > CNT_W'(DEPTH), "entry count above depth")
    `ASSERT_CLK(a_count_step, count_reg != $past(count_reg) |-> (count_reg == $past(count_reg) + CNT_W'(1) || count_reg == $past(count_reg) - CNT_W'(1)), "entry count moved by more than one")
    `ASSERT_CLK(a_push_room, ram_wr_en && state_reg == ST_PUSH_WR |-> count_reg < limit_eff, "push written past the limit")
    `ASSERT_CLK(a_result_from_done, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE), "result shown outside completion")

endmodule

// ===== rtl/core/cmbq_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module cmbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// testbench for the class-matched bounded queue: directed and random push/take traffic
module tb_top;
    import cmbq_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    in_t              in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_t             out_data;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    // shadow of the queue contents and the limit register
    entry_t           shadow_fifo[$];
    logic [CNT_W-1:0] limit_shadow = LIMIT_RESET;
    out_t             pending_results[$];
    out_t             expected_head;

    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    bit  offering       = 1'b0;
    int  fail_count     = 0;
    int  n_sent         = 0;
    int  n_checked      = 0;
    int  n_push_ok      = 0;
    int  n_push_refused = 0;
    int  n_take_hit     = 0;
    int  n_take_miss    = 0;
    int  n_limit_writes = 0;

    class_matched_bounded_queue_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #150_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // work out the result of one item and update the shadow queue
    function automatic out_t predict_queue_op(in_t it);
        out_t   r;
        entry_t e;
        int     lim;
        int     n;
        int     hit;
        bit     prime;
        r   = '0;
        lim = (limit_shadow > DEPTH) ? DEPTH : int'(limit_shadow);
        if (it.opcode == OP_PUSH)
        begin
            if (shadow_fifo.size() < lim)
            begin
                // trial division by odd numbers up to the square root
                n     = int'($signed(it.item_value));
                prime = (n == 2) || (n > 2 && n[0]);
                for (int d = 3; prime && d * d <= n; d += 2)
                    if (n % d == 0)
                        prime = 1'b0;
                e.value = it.item_value;
                e.cls   = prime ? CLS_PRIME : (it.item_value[0] ? CLS_ODD : CLS_EVEN);
                shadow_fifo.push_back(e);
                r.op_ok = 1'b1;
                n_push_ok++;
            end
            else
                n_push_refused++;
        end
        else
        begin
            // oldest entry of the asked class, the rest close up behind it
            hit = -1;
            if (it.consumer_class != CLS_NONE)
                for (int i = 0; i < shadow_fifo.size() && hit < 0; i++)
                    if (shadow_fifo[i].cls == it.consumer_class)
                        hit = i;
            if (hit >= 0)
            begin
                r.op_ok       = 1'b1;
                r.taken_value = shadow_fifo[hit].value;
                shadow_fifo.delete(hit);
                n_take_hit++;
            end
            else
                n_take_miss++;
        end
        r.occupancy = CNT_W'(shadow_fifo.size());
        return r;
    endfunction

    function automatic in_t make_item(logic op, logic signed [VAL_W-1:0] v,
                                      logic [CLS_W-1:0] c);
        in_t it;
        it.opcode         = op;
        it.item_value     = v;
        it.consumer_class = c;
        return it;
    endfunction

    // offer one item, with a random gap first, and record its expected result
    task automatic send_item(in_t it);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_queue_op(it));
        n_sent++;
    endtask

    // hold the sender off until every expected result is back
    task automatic wait_for_results();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // limit register written only with the block idle
    task automatic write_queue_limit(logic [CNT_W-1:0] lim);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we       <= 1'b0;
        limit_shadow = lim;
        n_limit_writes++;
    endtask

    // result checker and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: ok=%0b value=%0d occupancy=%0d",
                             out_data.op_ok, out_data.taken_value, out_data.occupancy);
            end
            else
            begin
                expected_head = pending_results.pop_front();
                n_checked++;
                if (out_data.op_ok !== expected_head.op_ok ||
                    out_data.taken_value !== expected_head.taken_value ||
                    out_data.occupancy !== expected_head.occupancy)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch on result %0d: expected ok=%0b value=%0d occ=%0d, %s",
                                 n_checked, expected_head.op_ok, expected_head.taken_value,
                                 expected_head.occupancy,
                                 $sformatf("got ok=%0b value=%0d occ=%0d", out_data.op_ok,
                                           out_data.taken_value, out_data.occupancy));
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // empty takes, value extremes, a full queue and a take of every class
    task automatic test_directed_cases();
        logic signed [VAL_W-1:0] fill_vals[16];
        fill_vals = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, 16'sd2, 16'sd3, -16'sd1, 16'sd4,
                      16'sd9, 16'sd15, 16'sd32749, -16'sd7, 16'sd25, 16'sd6, 16'sd17, 16'sd8};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // nothing to take yet
        send_item(make_item(OP_TAKE, 16'sd0, CLS_EVEN));
        send_item(make_item(OP_TAKE, -16'sd1, CLS_NONE));
        // fill to the reset limit, then one push too many
        foreach (fill_vals[i])
            send_item(make_item(OP_PUSH, fill_vals[i], CLS_W'($urandom_range(0, 3))));
        send_item(make_item(OP_PUSH, 16'sd5, CLS_PRIME));
        // class three never matches, then one take of each real class
        send_item(make_item(OP_TAKE, 16'sd0, CLS_NONE));
        send_item(make_item(OP_TAKE, 16'sh7FFF, CLS_PRIME));
        send_item(make_item(OP_TAKE, 16'sh8000, CLS_ODD));
        send_item(make_item(OP_TAKE, -16'sd1, CLS_EVEN));
        wait_for_results();
    endtask

    // random push/take traffic over three limit settings
    task automatic test_random_traffic(int snd_pct, int rcv_pct, int lim_a, int lim_b,
                                       int lim_c, int n_items);
        int  lims[3];
        in_t it;
        int  lim;
        int  push_pct;
        int  sv;
        lims          = '{lim_a, lim_b, lim_c};
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int seg = 0; seg < 3; seg++)
        begin
            write_queue_limit(CNT_W'(lims[seg]));
            repeat (n_items / 3)
            begin
                // keep the fill level wandering between empty and the limit
                lim = (limit_shadow > DEPTH) ? DEPTH : int'(limit_shadow);
                if (shadow_fifo.size() == 0)
                    push_pct = 85;
                else if (shadow_fifo.size() >= lim)
                    push_pct = 25;
                else
                    push_pct = 55;
                it.opcode = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_TAKE;
                // mostly small values so primality stays quick, some full range
                if ($urandom_range(0, 99) < 70)
                begin
                    sv            = int'($urandom_range(0, 575)) - 64;
                    it.item_value = sv[VAL_W-1:0];
                end
                else
                    it.item_value = VAL_W'($urandom);
                // mostly ask for a class that is present
                if (shadow_fifo.size() != 0 && $urandom_range(0, 99) < 75)
                    it.consumer_class =
                        shadow_fifo[$urandom_range(0, shadow_fifo.size() - 1)].cls;
                else
                    it.consumer_class = CLS_W'($urandom_range(0, 3));
                send_item(it);
            end
        end
        wait_for_results();
    endtask

    // test sequence
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(33, 58, 16, 0, 5, 616);
        test_random_traffic(58, 33, 31, 1, 9, 616);
        test_random_traffic(0, 0, 2, 16, 12, 616);
        // settle, then anything still outstanding is a failure
        repeat (50) @(posedge clk);
        fail_count += pending_results.size();
        $display("covered %0d items: %0d pushes stored, %0d refused, %0d takes hit, %0d missed",
                 n_sent, n_push_ok, n_push_refused, n_take_hit, n_take_miss);
        $display("%0d results checked across %0d limit writes, %0d failures",
                 n_checked, n_limit_writes, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
